>>> rtl/idiv_pkg.sv
// Package for the pipelined integer divider.
// Holds the sign-correction flag type and fixed port widths; no dependencies.
package idiv_pkg;

    // Width of the top-level data ports, fixed by the interface
    localparam int unsigned PORT_WIDTH = 64;

    // Sign corrections to apply once the magnitude division finishes
    typedef struct packed {
        logic neg_q;
        logic neg_r;
    } t_sign;

endpackage

>>> rtl/idiv_prep.sv
// Operand stage: masks the operands to the data width and takes magnitudes.
// Depends on idiv_pkg.
module idiv_prep #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_kind,
    input  logic [idiv_pkg::PORT_WIDTH-1:0]     i_dividend,
    input  logic [idiv_pkg::PORT_WIDTH-1:0]     i_divisor,
    output logic                                o_valid,
    output logic [DATA_WIDTH-1:0]               o_num,
    output logic [DATA_WIDTH-1:0]               o_den,
    output idiv_pkg::t_sign                     o_sign
);
    import idiv_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_num, n_num;
    logic [DATA_WIDTH-1:0] r_den, n_den;
    t_sign                 r_sign, n_sign;
    logic [DATA_WIDTH-1:0] a, b;
    logic                  a_neg, b_neg;

    always_comb begin
        a      = i_dividend[DATA_WIDTH-1:0];
        b      = i_divisor[DATA_WIDTH-1:0];
        a_neg  = i_kind & a[DATA_WIDTH-1];
        b_neg  = i_kind & b[DATA_WIDTH-1];
        n_num  = a_neg ? (DATA_WIDTH'(0) - a) : a;
        n_den  = b_neg ? (DATA_WIDTH'(0) - b) : b;
        n_sign.neg_q = a_neg ^ b_neg;
        n_sign.neg_r = a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_sign <= n_sign;
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_sign  = r_sign;

endmodule

>>> rtl/idiv_step.sv
// One restoring division step: shift in a dividend bit, trial-subtract, keep or restore.
// Depends on idiv_pkg.
module idiv_step #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    input  idiv_pkg::t_sign       i_sign,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_num,
    output logic [DATA_WIDTH-1:0] o_den,
    output idiv_pkg::t_sign       o_sign
);
    import idiv_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_num, n_num;
    logic [DATA_WIDTH-1:0] r_den;
    t_sign                 r_sign;
    logic [DATA_WIDTH:0]   trial, diff;
    logic                  ge;

    // i_num holds unused dividend bits at the top and quotient bits at the bottom
    always_comb begin
        trial = {i_rem, i_num[DATA_WIDTH-1]};
        diff  = trial - {1'b0, i_den};
        ge    = trial >= {1'b0, i_den};
        n_rem = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        n_num = {i_num[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_den  <= i_den;
        r_sign <= i_sign;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_sign  = r_sign;

endmodule

>>> rtl/idiv_fix.sv
// Result stage: applies the sign corrections and registers the result strobe.
// Depends on idiv_pkg.
module idiv_fix #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [DATA_WIDTH-1:0]           i_quot,
    input  logic [DATA_WIDTH-1:0]           i_rem,
    input  idiv_pkg::t_sign                 i_sign,
    output logic                            o_valid,
    output logic [idiv_pkg::PORT_WIDTH-1:0] o_quotient,
    output logic [idiv_pkg::PORT_WIDTH-1:0] o_remainder
);
    import idiv_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_quot, n_quot;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;

    always_comb begin
        n_quot = i_sign.neg_q ? (DATA_WIDTH'(0) - i_quot) : i_quot;
        n_rem  = i_sign.neg_r ? (DATA_WIDTH'(0) - i_rem) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_valid     = r_valid;
    assign o_quotient  = PORT_WIDTH'(r_quot);
    assign o_remainder = PORT_WIDTH'(r_rem);

endmodule

>>> rtl/int64_restoring_divider_core.sv
// Top level of the pipelined signed/unsigned restoring divider.
// Depends on idiv_pkg, idiv_prep, idiv_step and idiv_fix.
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------------------
// command   in         start & !busy             i_kind, i_dividend, i_divisor
// result    out        o_valid (one-cycle pulse) o_quotient, o_remainder
//
// The pipeline is one operand stage, one stage per quotient bit (each a
// single trial subtract of DATA_WIDTH + 1 bits), and one sign-correction
// stage, each of them registered.
// A new transaction is taken every cycle; busy stays low throughout.
// Reset clears only the valid bits travelling with the data, so any
// transaction in flight is dropped and nothing is emitted for it.
// The receiver cannot stall, so the pipeline always advances.
module int64_restoring_divider_core #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_kind,
    input  logic [idiv_pkg::PORT_WIDTH-1:0] i_dividend,
    input  logic [idiv_pkg::PORT_WIDTH-1:0] i_divisor,
    output logic                            o_valid,
    output logic [idiv_pkg::PORT_WIDTH-1:0] o_quotient,
    output logic [idiv_pkg::PORT_WIDTH-1:0] o_remainder
);
    import idiv_pkg::*;

    // Stage links: index 0 is the operand stage output, index k+1 the output of step k
    logic                  s_valid [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_num   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_den   [0:DATA_WIDTH];
    t_sign                 s_sign  [0:DATA_WIDTH];

    // Nothing downstream can push back, so never refuse a command
    assign busy = 1'b0;

    // Take magnitudes and note which signs to restore at the end
    idiv_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start & ~busy),
        .i_kind     (i_kind),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (s_valid[0]),
        .o_num      (s_num[0]),
        .o_den      (s_den[0]),
        .o_sign     (s_sign[0])
    );

    // Partial remainder starts at zero
    assign s_rem[0] = '0;

    // One step per quotient bit, most significant bit first
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        idiv_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_rem   (s_rem[k]),
            .i_num   (s_num[k]),
            .i_den   (s_den[k]),
            .i_sign  (s_sign[k]),
            .o_valid (s_valid[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_num   (s_num[k+1]),
            .o_den   (s_den[k+1]),
            .o_sign  (s_sign[k+1])
        );
    end

    // After the last step the shift register holds the magnitude quotient
    idiv_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_valid[DATA_WIDTH]),
        .i_quot      (s_num[DATA_WIDTH]),
        .i_rem       (s_rem[DATA_WIDTH]),
        .i_sign      (s_sign[DATA_WIDTH]),
        .o_valid     (o_valid),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

endmodule

>>> rtl/idiv_check.sv
// Port-level checks for the pipelined divider, bound to the top level.
// Depends on idiv_pkg and int64_restoring_divider_core.
module idiv_check #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_kind,
    input logic [idiv_pkg::PORT_WIDTH-1:0] i_dividend,
    input logic [idiv_pkg::PORT_WIDTH-1:0] i_divisor,
    input logic                            o_valid,
    input logic [idiv_pkg::PORT_WIDTH-1:0] o_quotient,
    input logic [idiv_pkg::PORT_WIDTH-1:0] o_remainder
);
    import idiv_pkg::*;

    localparam int unsigned LAT = DATA_WIDTH + 2;
    localparam logic [PORT_WIDTH-1:0] MASK = PORT_WIDTH'({DATA_WIDTH{1'b1}});
    localparam logic [DATA_WIDTH-1:0] ONE  = DATA_WIDTH'(1);

    // Every accepted transaction yields a result after the fixed latency
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a transaction behind it
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_valid)
        else $error("result without an accepted transaction");

    // Unsigned division by one returns the dividend with zero remainder
    a_div_by_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_kind && (i_divisor[DATA_WIDTH-1:0] == ONE))
        |-> ##LAT (o_quotient == ($past(i_dividend, LAT) & MASK))
              && (o_remainder == '0))
        else $error("unsigned division by one gave a wrong result");

    // Result bits above the data width stay clear
    a_upper_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_quotient | o_remainder) & ~MASK) == '0))
        else $error("result bits above the data width set");

endmodule

bind int64_restoring_divider_core idiv_check #(
    .DATA_WIDTH (DATA_WIDTH)
) u_idiv_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_kind      (i_kind),
    .i_dividend  (i_dividend),
    .i_divisor   (i_divisor),
    .o_valid     (o_valid),
    .o_quotient  (o_quotient),
    .o_remainder (o_remainder)
);
